[src/isr_pkg.sv]
// Shared constants and width helpers for the integer square root block.
package isr_pkg;

  // Width of the root result port.
  localparam int ROOT_W = 16;

  // Root bits needed for a radicand magnitude of the given width.
  function automatic int root_bits(input int value_width);
    root_bits = (value_width + 1) >> 1;
  endfunction

endpackage

[src/isr_mag.sv]
// Entry stage: captures a radicand and registers its magnitude and sign.
module isr_mag import isr_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  logic [VALUE_WIDTH-1:0]               radicand,
  output logic                                 valid_o,
  output logic [2*root_bits(VALUE_WIDTH)-1:0]  rad_o,
  output logic                                 neg_o
);

  localparam int RW = root_bits(VALUE_WIDTH);

  logic                   valid_r;
  logic [2*RW-1:0]        rad_r;
  logic                   neg_r;
  logic                   neg_nxt;
  logic [VALUE_WIDTH-1:0] mag_nxt;

  // Most negative input maps to 2^(W-1), exact as an unsigned value.
  assign neg_nxt = radicand[VALUE_WIDTH-1];
  assign mag_nxt = neg_nxt ? (~radicand + VALUE_WIDTH'(1)) : radicand;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rad_r <= (2*RW)'(mag_nxt);
      neg_r <= neg_nxt;
    end
  end

  assign valid_o = valid_r;
  assign rad_o   = rad_r;
  assign neg_o   = neg_r;

endmodule

[src/isr_cell.sv]
// One recurrence cell: settles one root bit and hands its state to the next cell.
module isr_cell import isr_pkg::*; #(
  parameter int RW = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_i,
  input  logic [RW+1:0]   rem_i,
  input  logic [RW-1:0]   root_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic            neg_i,
  output logic            valid_o,
  output logic [RW+1:0]   rem_o,
  output logic [RW-1:0]   root_o,
  output logic [2*RW-1:0] rad_o,
  output logic            neg_o
);

  logic            valid_r;
  logic [RW+1:0]   rem_r;
  logic [RW-1:0]   root_r;
  logic [2*RW-1:0] rad_r;
  logic            neg_r;

  logic [RW+1:0]   rem_sh;
  logic [RW+1:0]   trial;
  logic            fits;
  logic [RW+1:0]   rem_nxt;
  logic [RW-1:0]   root_nxt;

  // Bring down the next two radicand bits; trial subtrahend is 4*root + 1.
  assign rem_sh   = {rem_i[RW-1:0], rad_i[2*RW-1 -: 2]};
  assign trial    = {root_i, 2'b01};
  assign fits     = (rem_sh >= trial);
  assign rem_nxt  = fits ? (rem_sh - trial) : rem_sh;
  assign root_nxt = {root_i[RW-2:0], fits};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    rad_r  <= {rad_i[2*RW-3:0], 2'b00};
    neg_r  <= neg_i;
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;
  assign rad_o   = rad_r;
  assign neg_o   = neg_r;

endmodule

[src/integer_square_root.sv]
// Integer square root: floor(sqrt(|radicand|)) with a negative-input flag.
//
// Command interface: a radicand is transferred at a rising edge where start
// is high and busy is low. One item is in flight at a time.
// The result appears on out_root / out_negative_input for exactly one cycle
// with out_valid high; the receiver has no way to stall it.
// Path: the magnitude stage registers the transferred radicand and sign,
// then each of the RW cells (RW = ceil(VALUE_WIDTH/2), 16 for the default
// width) registers its step in turn; the register of the last cell drives
// the result. Each cell settles one root bit. A new radicand is not taken
// while one is in flight: busy drops in the result cycle, so the next
// start is taken at its closing edge.
// Reset (rst_n low, synchronous) clears all valid bits; no result is
// produced for an item in flight at reset.
// Zero gives root 0. The most negative radicand is taken as 2^(W-1) exactly.
module integer_square_root import isr_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] in_radicand,
  output logic                   out_valid,
  output logic [ROOT_W-1:0]      out_root,
  output logic                   out_negative_input
);

  localparam int RW = root_bits(VALUE_WIDTH);

  logic            accept;
  logic            valid_c [0:RW];
  logic [RW+1:0]   rem_c   [0:RW];
  logic [RW-1:0]   root_c  [0:RW];
  logic [2*RW-1:0] rad_c   [0:RW];
  logic            neg_c   [0:RW];
  logic [RW-1:0]   busy_vec;

  assign accept = start && !busy;

  isr_mag #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_mag (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .radicand (in_radicand),
    .valid_o  (valid_c[0]),
    .rad_o    (rad_c[0]),
    .neg_o    (neg_c[0])
  );

  assign rem_c[0]  = '0;
  assign root_c[0] = '0;

  for (genvar i = 0; i < RW; i++) begin : g_cell
    isr_cell #(
      .RW (RW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (valid_c[i]),
      .rem_i   (rem_c[i]),
      .root_i  (root_c[i]),
      .rad_i   (rad_c[i]),
      .neg_i   (neg_c[i]),
      .valid_o (valid_c[i+1]),
      .rem_o   (rem_c[i+1]),
      .root_o  (root_c[i+1]),
      .rad_o   (rad_c[i+1]),
      .neg_o   (neg_c[i+1])
    );
  end

  // Busy while the item is anywhere but the last cell.
  for (genvar i = 0; i < RW; i++) begin : g_busy
    assign busy_vec[i] = valid_c[i];
  end
  assign busy = |busy_vec;

  assign out_valid          = valid_c[RW];
  assign out_negative_input = neg_c[RW];

  if (RW >= ROOT_W) begin : g_root_trunc
    assign out_root = root_c[RW][ROOT_W-1:0];
  end else begin : g_root_ext
    assign out_root = ROOT_W'(root_c[RW]);
  end

  // Remainder never reaches bit RW+1 after a step.
  a_rem_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !rem_c[RW][RW+1])
    else $error("remainder out of range at result");

  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after transfer");

  a_result_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while another item in flight");

  a_single_item : assert property (@(posedge clk) disable iff (!rst_n)
    $countones({busy_vec, out_valid}) <= 1)
    else $error("more than one item in the cell chain");

endmodule
